@@ rtl/core/ciss_pkg.sv @@
// Shared types, constants and helpers for the case-insensitive substring search.
`default_nettype none
package ciss_pkg;

  // Sizing
  localparam int PATTERN_MAX   = 16;
  localparam int POSITION_BITS = 16;
  localparam int OFFSET_BITS   = 16;
  localparam int LEN_BITS      = 5;
  localparam int REG_BITS      = 64;
  localparam int CFG_ADDR_BITS = 2;
  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_DATA_BITS = 24;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2
  } cfg_index_t;

  // Configuration as seen by the match logic
  typedef struct packed {
    logic [LEN_BITS-1:0] length;
    logic [REG_BITS-1:0] pat_high;
    logic [REG_BITS-1:0] pat_low;
  } cfg_t;

  // One result request
  typedef struct packed {
    logic                   ovf;
    logic [OFFSET_BITS-1:0] offset;
    logic                   found;
  } res_t;

  // Map a to z onto A to Z, all other codes unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      f = c - 8'h20;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ciss_cfg_regs.sv @@
// Configuration registers: pattern length and the sixteen pattern bytes.
`default_nettype none
module ciss_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ciss_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [ciss_pkg::REG_BITS-1:0]      cfg_wdata,
  output ciss_pkg::cfg_t                          cfg
);
  import ciss_pkg::*;

  logic [LEN_BITS-1:0] length_r;
  logic [REG_BITS-1:0] pat_low_r;
  logic [REG_BITS-1:0] pat_high_r;

  // Register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r   <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_PATTERN_LENGTH: length_r   <= cfg_wdata[LEN_BITS-1:0];
        CFG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.length   = length_r;
  assign cfg.pat_low  = pat_low_r;
  assign cfg.pat_high = pat_high_r;

endmodule
`default_nettype wire

@@ rtl/core/ciss_match_core.sv @@
// Input register, bit-parallel match vector and per-string position tracking.
`default_nettype none
module ciss_match_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  ciss_pkg::cfg_t                         cfg,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ciss_pkg::IN_DATA_BITS-1:0] in_byte,
  input  wire logic                              in_last,
  input  wire logic                              res_ready,
  output logic                                   res_valid,
  output ciss_pkg::res_t                         res
);
  import ciss_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

  // Input register
  logic                    s1_valid_r;
  logic [IN_DATA_BITS-1:0] s1_byte_r;
  logic                    s1_last_r;

  // Per-string state
  logic [PATTERN_MAX-1:0]   pm_r,    pm_nxt;
  logic [POSITION_BITS-1:0] pos_r,   pos_nxt;
  logic                     seen_r,  seen_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic                     sat_r,   sat_nxt;

  logic                     s1_ends;
  logic                     s1_adv;
  logic                     take;
  logic [LEN_BITS-1:0]      act_len;
  logic [LEN_BITS-1:0]      len_m1;
  logic [PATTERN_MAX-1:0]   eq;
  logic [PATTERN_MAX-1:0]   pm_take;
  logic                     hit;
  logic [7:0]               text_fold;
  logic [2*REG_BITS-1:0]    pat_all;
  logic                     wide;

  // Stage control: a result request needs room in the result register
  assign s1_ends  = s1_valid_r && (s1_byte_r == '0 || s1_last_r);
  assign s1_adv   = s1_valid_r && (!s1_ends || res_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign take     = s1_adv && (s1_byte_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  // Active pattern length, clamped to the pattern store
  always_comb begin
    act_len = cfg.length;
    if (cfg.length > LEN_BITS'(PATTERN_MAX)) begin
      act_len = LEN_BITS'(PATTERN_MAX);
    end
    len_m1 = act_len - LEN_BITS'(1);
  end

  // Per-byte compare vector; a zero pattern byte never matches
  assign pat_all   = {cfg.pat_high, cfg.pat_low};
  assign text_fold = fold_case(s1_byte_r);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq[i] = (LEN_BITS'(i) < act_len) && (pat_all[8*i +: 8] != 8'h00) &&
              (fold_case(pat_all[8*i +: 8]) == text_fold);
    end
  end

  assign pm_take = {pm_r[PATTERN_MAX-2:0], 1'b1} & eq;
  assign hit     = (act_len != '0) && pm_take[len_m1[$clog2(PATTERN_MAX)-1:0]];

  // Next per-string state; a result clears it for the next string
  always_comb begin
    pm_nxt    = pm_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    start_nxt = start_r;
    sat_nxt   = sat_r;
    if (take) begin
      pm_nxt = pm_take;
      if (pos_r == POS_LIMIT) begin
        sat_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
      if (!seen_r && hit) begin
        seen_nxt = 1'b1;
        if (sat_nxt || pos_r < POSITION_BITS'(len_m1)) begin
          start_nxt = POS_LIMIT;
        end else begin
          start_nxt = pos_r - POSITION_BITS'(len_m1);
        end
      end
    end
  end

  // Result fields from the state after this byte
  assign wide       = (start_nxt >> OFFSET_BITS) != '0;
  assign res_valid  = s1_adv && s1_ends;
  assign res.found  = seen_nxt;
  assign res.offset = !seen_nxt ? '0 : (wide ? '1 : OFFSET_BITS'(start_nxt));
  assign res.ovf    = sat_nxt || (seen_nxt && wide);

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      pm_r    <= '0;
      pos_r   <= '0;
      seen_r  <= 1'b0;
      start_r <= '0;
      sat_r   <= 1'b0;
    end else begin
      pm_r    <= pm_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      start_r <= start_nxt;
      sat_r   <= sat_nxt;
    end
  end

`ifndef SYNTH
  // A delivered result leaves a clean string state behind
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == '0 && !seen_r && !sat_r && pm_r == '0))
    else $error("string state not cleared after result");

  // Saturation only happens at the counter limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (pos_r == POS_LIMIT))
    else $error("saturated flag without counter at limit");

  // No recorded start without a match
  a_start_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (start_r == '0))
    else $error("match start recorded without a match");
`endif

endmodule
`default_nettype wire

@@ rtl/core/ciss_result_reg.sv @@
// Output register holding one result request until the sink takes it.
`default_nettype none
module ciss_result_reg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                res_valid,
  input  ciss_pkg::res_t                           res,
  output logic                                     res_ready,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ciss_pkg::OUT_DATA_BITS-1:0]       out_tdata
);
  import ciss_pkg::*;

  logic valid_r;
  res_t data_r;

  assign res_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_DATA_BITS'(data_r);

endmodule
`default_nettype wire

@@ rtl/core/case_insensitive_substring_search.sv @@
// Top level of the case-insensitive substring search.
`default_nettype none
// Streams text one byte per request and reports, once per string, whether a
// pattern of up to 16 bytes occurs in it (a-z equal A-Z) and where the first
// occurrence starts. A zero byte or tlast ends the string; the zero byte is
// not text. One byte is taken every cycle; only an ending byte can stall the
// input, while the result register still holds a result the sink has not
// taken. An ending byte waits in the input register and its result is then
// loaded into the result register, which drives the output. The bit-parallel
// partial-match vector between the two registers sets the byte rate. The user
// must write configuration while no string is in flight; nothing enforces it.
module case_insensitive_substring_search (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ciss_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [ciss_pkg::REG_BITS-1:0]      cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ciss_pkg::IN_DATA_BITS-1:0]  in_tdata,   // [7:0] text_byte
  input  wire logic                               in_tlast,   // end_of_text
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [0] found, [16:1] match_offset, [17] offset_overflow, [23:18] zero
  output logic [ciss_pkg::OUT_DATA_BITS-1:0]      out_tdata
);
  import ciss_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_ready;

  ciss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ciss_match_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  ciss_result_reg u_res (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the case-insensitive substring search top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ciss_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 12;
  localparam int CYCLE_LIMIT      = 100_000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int ITEMS_PER_PHASE  = 80;
  localparam int MAX_PRINTS       = 40;
  localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 1;

  // One text request as the sender offers it
  typedef struct {
    logic [7:0] text;
    logic       last;
  } text_req_t;

  // Receiver stall patterns
  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [REG_BITS-1:0]      cfg_wdata = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;   // [7:0] text_byte
  logic                     in_tlast = 1'b0; // end_of_text
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  // [0] found, [16:1] match_offset, [17] offset_overflow, [23:18] zero
  logic [OUT_DATA_BITS-1:0] out_tdata;

  case_insensitive_substring_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow of the pattern registers
  logic [LEN_BITS-1:0] pat_len = '0;
  logic [REG_BITS-1:0] pat_lo = '0;
  logic [REG_BITS-1:0] pat_hi = '0;

  // Per-string search state of the predictor
  logic [15:0]     partial = '0;
  longint unsigned text_pos = 0;
  longint unsigned first_start = 0;
  bit              match_seen = 1'b0;
  bit              pos_sat = 1'b0;

  text_req_t send_q[$];
  res_t      match_q[$];
  res_t      want;

  int       err_count = 0;
  longint   cycle_count = 0;
  int       items_queued = 0;
  int       tx_burst = 1;
  int       tx_gap = 0;
  text_req_t tx_cur;
  int       rx_hold_req = 0;
  int       rx_hold_done = 0;
  int       rx_hold_left = 0;
  int       rx_mode_left = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_FREE;

  // Clock and reset
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int active_len();
    return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
  endfunction

  function automatic logic [7:0] pat_byte(int i);
    return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
  endfunction

  // ASCII letters compare without regard to case, all else exactly
  function automatic bit same_letter(logic [7:0] a, logic [7:0] b);
    logic [7:0] ua;
    logic [7:0] ub;
    ua = (a >= 8'h61 && a <= 8'h7A) ? a - 8'h20 : a;
    ub = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    return ua == ub;
  endfunction

  // Advance the search by one accepted request; queue a result at string end
  function automatic void consume_text(logic [7:0] c, logic last);
    int              n;
    int              i;
    longint unsigned here;
    logic [15:0]     hits;
    res_t            r;
    n = active_len();
    if (c != 8'h00) begin
      here = text_pos;
      if (text_pos == POS_LIMIT) begin
        pos_sat = 1'b1;
      end else begin
        text_pos = text_pos + 1;
      end
      if (n == 0) begin
        partial = '0;
      end else begin
        hits = '0;
        for (i = 0; i < n; i++) begin
          if (pat_byte(i) != 8'h00 && same_letter(pat_byte(i), c)) begin
            hits[i] = 1'b1;
          end
        end
        partial = {partial[14:0], 1'b1} & hits;
        if (!match_seen && partial[n-1]) begin
          match_seen = 1'b1;
          if (pos_sat || here < longint'(n - 1)) begin
            first_start = POS_LIMIT;
          end else begin
            first_start = here - longint'(n - 1);
          end
        end
      end
    end
    if (c == 8'h00 || last) begin
      r.found  = match_seen;
      r.offset = '0;
      r.ovf    = pos_sat;
      if (match_seen) begin
        if (first_start > 64'hFFFF) begin
          r.offset = '1;
          r.ovf    = 1'b1;
        end else begin
          r.offset = first_start[15:0];
        end
      end
      match_q.push_back(r);
      partial     = '0;
      text_pos    = 0;
      match_seen  = 1'b0;
      first_start = 0;
      pos_sat     = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        consume_text(in_tdata, in_tlast);
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (send_q.size() != 0) begin
          tx_cur = send_q.pop_front();
          in_tdata  <= tx_cur.text;
          in_tlast  <= tx_cur.last;
          in_tvalid <= 1'b1;
          tx_burst--;
          if (tx_burst <= 0) begin
            tx_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
            tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: changing stall patterns plus requested long hold-offs
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (rx_hold_done != rx_hold_req) begin
      rx_hold_done = rx_hold_req;
      rx_hold_left = LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 200);
      end else begin
        rx_mode_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_FREE:     out_tready <= 1'b1;
        RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
        default:     out_tready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_val);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, what, got, exp_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (match_q.size() == 0) begin
        report_mismatch("result with none outstanding", out_tdata, 0);
      end else begin
        want = match_q.pop_front();
        if (out_tdata[0] !== want.found) begin
          report_mismatch("found", out_tdata[0], want.found);
        end
        if (out_tdata[16:1] !== want.offset) begin
          report_mismatch("match_offset", out_tdata[16:1], want.offset);
        end
        if (out_tdata[17] !== want.ovf) begin
          report_mismatch("offset_overflow", out_tdata[17], want.ovf);
        end
        if (out_tdata[OUT_DATA_BITS-1:18] !== '0) begin
          report_mismatch("padding", out_tdata[OUT_DATA_BITS-1:18], 0);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] c, logic last);
    text_req_t t;
    t.text = c;
    t.last = last;
    send_q.push_back(t);
    items_queued++;
  endtask

  // Wait until every request is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (send_q.size() != 0 || in_tvalid || match_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [REG_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_PATTERN_LENGTH: pat_len = val[LEN_BITS-1:0];
      CFG_PATTERN_LOW:    pat_lo  = val;
      CFG_PATTERN_HIGH:   pat_hi  = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
        $urandom_range(0, 1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // Pattern bytes lean on a few letters so partial matches overlap often
  function automatic logic [7:0] rand_pat_byte(bit allow_zero);
    if (allow_zero && $urandom_range(0, 39) == 0) begin
      return 8'h00;
    end
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom_range(1, 255));
    end
    return flip_case(8'($urandom_range('h41, 'h44)));
  endfunction

  task automatic set_pattern(logic [LEN_BITS-1:0] len, bit allow_zero);
    logic [REG_BITS-1:0] lo;
    logic [REG_BITS-1:0] hi;
    int i;
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = rand_pat_byte(allow_zero);
      hi[8*i +: 8] = rand_pat_byte(allow_zero);
    end
    write_reg(CFG_PATTERN_LENGTH, REG_BITS'(len));
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
  endtask

  function automatic logic [7:0] filler_byte();
    int n;
    n = active_len();
    if (n > 0 && $urandom_range(0, 1) == 1) begin
      return flip_case(pat_byte($urandom_range(0, n - 1)));
    end
    return 8'($urandom_range(1, 255));
  endfunction

  // One string: mostly filler with the pattern (or a prefix) planted in it,
  // sometimes raw noise; ends on a flagged byte or a zero byte
  task automatic queue_random_string();
    logic [7:0] s[$];
    int n;
    int k;
    int at;
    int i;
    bit by_flag;
    n = active_len();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 20)) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 14)) s.push_back(filler_byte());
      if (n > 0 && $urandom_range(0, 3) != 0) begin
        k  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
        at = $urandom_range(0, s.size());
        for (i = k - 1; i >= 0; i--) begin
          s.insert(at, flip_case(pat_byte(i)));
        end
      end
    end
    by_flag = (s.size() != 0) && ($urandom_range(0, 3) != 0);
    for (i = 0; i < s.size(); i++) begin
      push_byte(s[i], by_flag && (i == s.size() - 1));
    end
    if (!by_flag) begin
      push_byte(8'h00, 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int ph;
    int start_items;
    logic [LEN_BITS-1:0] len;

    do @(posedge clk);
    while (!rst_n);

    // Empty pattern at reset; a one-byte string, then an empty string
    push_byte("A", 1'b1);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // Three-byte mixed-case pattern
    write_reg(CFG_PATTERN_LENGTH, REG_BITS'(3));
    write_reg(CFG_PATTERN_LOW, 64'h0000_0000_0063_4261);
    write_reg(CFG_PATTERN_HIGH, '0);
    push_byte("x", 1'b0);
    push_byte("A", 1'b0);
    push_byte("b", 1'b0);
    push_byte("C", 1'b1);
    // match then zero terminator, flag left low
    push_byte("a", 1'b0);
    push_byte("b", 1'b0);
    push_byte("c", 1'b0);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // Zero byte inside the pattern can never match
    write_reg(CFG_PATTERN_LENGTH, REG_BITS'(2));
    write_reg(CFG_PATTERN_LOW, 64'h0000_0000_0000_0041);
    write_reg(CFG_PATTERN_HIGH, '1);
    push_byte("a", 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // Length above the maximum acts as a full 16-byte pattern
    write_reg(CFG_PATTERN_LENGTH, REG_BITS'(31));
    write_reg(CFG_PATTERN_LOW, 64'h4847_4645_4443_4241);
    write_reg(CFG_PATTERN_HIGH, 64'h504F_4E4D_4C4B_4A49);
    for (ph = 0; ph < 16; ph++) begin
      push_byte(8'h61 + 8'(ph), ph == 15);
    end

    // Random phases, each under a fresh pattern, sender pauses in between
    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0:       len = 5'd1;
        1:       len = 5'd16;
        2:       len = 5'd0;
        3:       len = 5'd31;
        default: len = 5'($urandom_range(2, 15));
      endcase
      set_pattern(len, ph >= 4);
      if (ph == 1) begin
        @(negedge clk);
        rx_hold_req++;
      end
      start_items = items_queued;
      while (items_queued - start_items < ITEMS_PER_PHASE) begin
        queue_random_string();
      end
    end
    wait_idle();

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ciss_pkg.sv
rtl/core/ciss_cfg_regs.sv
rtl/core/ciss_match_core.sv
rtl/core/ciss_result_reg.sv
rtl/core/case_insensitive_substring_search.sv
tb/sv/tb_top.sv
